/* rtl/led_blink_sequencer_priority_queue_top_defines.svh */
// assertion macros shared by the rtl
`ifndef LED_BLINK_SEQUENCER_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define LED_BLINK_SEQUENCER_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// expression must hold on every clock edge outside reset
`define LBSPQ_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define LBSPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define LBSPQ_ASSERT_ALWAYS(label, clk, rst, expr)
`define LBSPQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/lbspq_pkg.sv */
`default_nettype none

package lbspq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int COUNT_W  = 8;
   localparam int DELAY_W  = 16;
   localparam int ENTRY_W  = COUNT_W + DELAY_W;
   localparam int LEVEL_W  = 5;
   localparam int STATUS_W = 2;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_ENQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DISABLED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_ENABLE      = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_QUEUE_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ON,
      PH_OFF
   } phase_type;

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } ctrl_state_type;

   typedef struct packed {
      logic enqueue;
      logic tick;
      logic pop;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pop_needed;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/lbspq_ram.sv */
`default_nettype none

module lbspq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/lbspq_ctrl.sv */
`default_nettype none

`include "led_blink_sequencer_priority_queue_top_defines.svh"

module lbspq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  req_cmd,
   input  wire lbspq_pkg::dp_status_type dp_status,
   output lbspq_pkg::ctrl_cmd_type    ctrl_cmd,
   output logic                       busy,
   output logic                       rsp_strobe
);

   import lbspq_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           strobe_ff, strobe_in;
   logic           accept;
   logic           pop_path;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      busy     = 1'b0;
      ctrl_cmd = '0;
      accept   = 1'b0;
      pop_path = 1'b0;
      strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            accept   = start;
            // a tick that finds the sequencer idle with work waiting reads the head first
            pop_path = (req_cmd == CMD_TICK) && dp_status.pop_needed;
            if (accept) begin
               if (req_cmd == CMD_ENQUEUE) begin
                  ctrl_cmd.enqueue = 1'b1;
                  strobe_in        = 1'b1;
               end else if (pop_path) begin
                  state_in = ST_POP;
               end else begin
                  ctrl_cmd.tick = 1'b1;
                  strobe_in     = 1'b1;
               end
            end
         end
         ST_POP: begin
            busy         = 1'b1;
            ctrl_cmd.pop = 1'b1;
            strobe_in    = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe = strobe_ff;

   `LBSPQ_ASSERT_NEXT(a_pop_one_cycle, clock, reset, state_ff == ST_POP, state_ff == ST_IDLE)
   `LBSPQ_ASSERT_NEXT(a_pop_gives_beat, clock, reset, state_ff == ST_POP, strobe_ff)
   `LBSPQ_ASSERT_NEXT(a_accept_beat, clock, reset,
      start && !busy && !(req_cmd == CMD_TICK && dp_status.pop_needed), strobe_ff)
   `LBSPQ_ASSERT_ALWAYS(a_cmd_exclusive, clock, reset,
      $onehot0({ctrl_cmd.enqueue, ctrl_cmd.tick, ctrl_cmd.pop}))

endmodule

`default_nettype wire

/* rtl/lbspq_dp.sv */
`default_nettype none

`include "led_blink_sequencer_priority_queue_top_defines.svh"

module lbspq_dp #(
   parameter int QUEUE_DEPTH = lbspq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire lbspq_pkg::ctrl_cmd_type               ctrl_cmd,
   output lbspq_pkg::dp_status_type                   dp_status,
   input  wire logic [lbspq_pkg::COUNT_W-1:0]         req_blink_count,
   input  wire logic [lbspq_pkg::DELAY_W-1:0]         req_delay_ticks,
   input  wire logic                                  req_high_priority,
   input  wire logic                                  csr_we,
   input  wire logic [lbspq_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [lbspq_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                       rsp_led_level,
   output logic [lbspq_pkg::STATUS_W-1:0]             rsp_status,
   output logic [lbspq_pkg::LEVEL_W-1:0]              rsp_queue_level,
   output logic                                       rsp_busy_res
);

   import lbspq_pkg::*;

   localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);
   localparam logic [8:0] Depth9  = 9'(QUEUE_DEPTH);
   localparam logic [9:0] Depth10 = 10'(QUEUE_DEPTH);

   logic [IdxW-1:0]     head_ff, head_in;
   logic [LEVEL_W-1:0]  count_ff, count_in;
   phase_type           phase_ff, phase_in;
   logic [DELAY_W-1:0]  timer_ff, timer_in;
   logic [COUNT_W-1:0]  blinks_ff, blinks_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic                led_ff, led_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                enable_ff;
   logic [LEVEL_W-1:0]  limit_ff;

   logic                wr_en;
   logic [IdxW-1:0]     wr_addr;
   logic [ENTRY_W-1:0]  rd_data;
   logic [8:0]          limit_wide;
   logic [8:0]          eff_limit;
   logic                full;
   logic [9:0]          tail_sum;
   logic [9:0]          tail_wrap;
   logic [IdxW-1:0]     head_prev;
   logic [IdxW-1:0]     head_next;
   logic [COUNT_W-1:0]  pop_count;
   logic [DELAY_W-1:0]  pop_delay;
   logic [COUNT_W-1:0]  blinks_dec;

   lbspq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_blink_count, req_delay_ticks}),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         phase_ff  <= PH_IDLE;
         timer_ff  <= '0;
         blinks_ff <= '0;
         delay_ff  <= '0;
         led_ff    <= 1'b0;
         status_ff <= STATUS_OK;
         enable_ff <= 1'b0;
         limit_ff  <= LEVEL_W'(16);
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
         blinks_ff <= blinks_in;
         delay_ff  <= delay_in;
         led_ff    <= led_in;
         status_ff <= status_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_ENABLE:      enable_ff <= csr_wdata[0];
               CSR_QUEUE_LIMIT: limit_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      limit_wide = {4'b0, limit_ff};
      if (limit_ff == '0) begin
         eff_limit = 9'd1;
      end else if (limit_wide > Depth9) begin
         eff_limit = Depth9;
      end else begin
         eff_limit = limit_wide;
      end
      full = {4'b0, count_ff} >= eff_limit;

      tail_sum  = 10'(head_ff) + 10'(count_ff);
      tail_wrap = (tail_sum >= Depth10) ? (tail_sum - Depth10) : tail_sum;
      head_prev = (head_ff == '0) ? LastIdx : (head_ff - 1'b1);
      head_next = (head_ff == LastIdx) ? '0 : (head_ff + 1'b1);

      pop_count  = rd_data[ENTRY_W-1:DELAY_W];
      // zero delay plays as one tick
      pop_delay  = (rd_data[DELAY_W-1:0] == '0) ? DELAY_W'(1) : rd_data[DELAY_W-1:0];
      blinks_dec = (blinks_ff != '0) ? (blinks_ff - 1'b1) : '0;
   end

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      blinks_in = blinks_ff;
      delay_in  = delay_ff;
      led_in    = led_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = IdxW'(tail_wrap);

      if (ctrl_cmd.enqueue) begin
         if (!enable_ff) begin
            status_in = STATUS_DISABLED;
         end else if (full) begin
            status_in = STATUS_FULL;
         end else begin
            status_in = STATUS_OK;
            wr_en     = 1'b1;
            count_in  = count_ff + 1'b1;
            if (req_high_priority) begin
               head_in = head_prev;
               wr_addr = head_prev;
            end
         end
      end

      if (ctrl_cmd.tick) begin
         status_in = STATUS_OK;
         if (phase_ff != PH_IDLE) begin
            if (timer_ff != '0) begin
               timer_in = timer_ff - 1'b1;
            end else if (phase_ff == PH_ON) begin
               led_in    = 1'b0;
               blinks_in = blinks_dec;
               if (blinks_dec != '0) begin
                  phase_in = PH_OFF;
                  timer_in = delay_ff - 1'b1;
               end else begin
                  phase_in = PH_IDLE;
               end
            end else begin
               led_in   = 1'b1;
               phase_in = PH_ON;
               timer_in = delay_ff - 1'b1;
            end
         end
      end

      if (ctrl_cmd.pop) begin
         status_in = STATUS_OK;
         head_in   = head_next;
         count_in  = count_ff - 1'b1;
         // zero count is dropped without playing
         if (pop_count != '0) begin
            blinks_in = pop_count;
            delay_in  = pop_delay;
            phase_in  = PH_ON;
            timer_in  = pop_delay - 1'b1;
            led_in    = 1'b1;
         end
      end
   end

   assign dp_status.pop_needed = (phase_ff == PH_IDLE) && (count_ff != '0);

   assign rsp_led_level   = led_ff;
   assign rsp_status      = status_ff;
   assign rsp_queue_level = count_ff;
   assign rsp_busy_res    = (phase_ff != PH_IDLE);

   `LBSPQ_ASSERT_ALWAYS(a_count_bound, clock, reset, {4'b0, count_ff} <= Depth9)
   `LBSPQ_ASSERT_ALWAYS(a_idle_led_off, clock, reset, (phase_ff != PH_IDLE) || !led_ff)
   `LBSPQ_ASSERT_ALWAYS(a_delay_set, clock, reset, (phase_ff == PH_IDLE) || (delay_ff != '0))
   `LBSPQ_ASSERT_NEXT(a_pop_takes_entry, clock, reset, ctrl_cmd.pop,
      count_ff == $past(count_ff) - 1'b1)

endmodule

`default_nettype wire

/* rtl/led_blink_sequencer_priority_queue_top.sv */
// blink command engine with a priority queue of blink commands
// input: pulse start with req_cmd and payload while busy is low; the item is
//   taken at that edge. req_cmd tick advances the blink sequencer one tick,
//   req_cmd enqueue adds a command at the head (high priority) or the tail.
// result: one beat per item, on rsp_strobe for exactly one cycle, carrying
//   the led level, status, queue level and play flag after the item.
// timing: the beat comes in the cycle after the accept edge; a tick that pops
//   the head command first passes through the pop state, for the registered
//   read of the command store ram, and holds busy high in that state.
// throughput: one item per cycle while busy is low.
// config: csr_we writes csr_wdata to register csr_addr (0 enable, 1 queue
//   limit); the user must do so while no item is in flight: not enforced.
// reset: synchronous, clears queue pointers, sequencer and led; enable
//   resets to 0 and the queue limit to 16. The store keeps old contents.
// the receiver cannot stall: every beat must be taken when it appears.
`default_nettype none

module led_blink_sequencer_priority_queue_top #(
   parameter int QUEUE_DEPTH = lbspq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic                                  req_cmd,
   input  wire logic [lbspq_pkg::COUNT_W-1:0]         req_blink_count,
   input  wire logic [lbspq_pkg::DELAY_W-1:0]         req_delay_ticks,
   input  wire logic                                  req_high_priority,
   output logic                                       rsp_strobe,
   output logic                                       rsp_led_level,
   output logic [lbspq_pkg::STATUS_W-1:0]             rsp_status,
   output logic [lbspq_pkg::LEVEL_W-1:0]              rsp_queue_level,
   output logic                                       rsp_busy_res,
   input  wire logic                                  csr_we,
   input  wire logic [lbspq_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [lbspq_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import lbspq_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   lbspq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_cmd    (req_cmd),
      .dp_status  (dp_status),
      .ctrl_cmd   (ctrl_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   lbspq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl_cmd          (ctrl_cmd),
      .dp_status         (dp_status),
      .req_blink_count   (req_blink_count),
      .req_delay_ticks   (req_delay_ticks),
      .req_high_priority (req_high_priority),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .rsp_led_level     (rsp_led_level),
      .rsp_status        (rsp_status),
      .rsp_queue_level   (rsp_queue_level),
      .rsp_busy_res      (rsp_busy_res)
   );

endmodule

`default_nettype wire
